### rtl/cmaf_pkg.sv
`default_nettype none

package cmaf_pkg;

    localparam int WINDOW_MAX  = 63;
    localparam int RING_DEPTH  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int RESULT_CAP  = 32;

    localparam int WIN_W     = 6;
    localparam int IDX_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int H_MAX   = (RING_DEPTH - 1) / 2;
    localparam int H_W     = $clog2(H_MAX + 1);
    localparam int CNT_W   = $clog2(2 * H_MAX + 2);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int VAL_W   = SAMPLE_BITS + 1;
    localparam int K_W     = $clog2(RESULT_CAP + 1);
    localparam int BIT_W   = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PASS_MODE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_TAIL,
        ST_DIVINIT,
        ST_DIV,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

### rtl/centered_moving_average_filter.sv
`default_nettype none

// Centered moving average over records of record_length samples. A sample is
// taken in the idle state; the block then emits every result that sample completes
// (normally one, the final sample of a record flushes the rest) and holds
// in_stall high until the sequencer has passed through its check state once
// more after the last of them has been loaded into the output register. With
// the output free, each result is made in these steps, in order: set up the
// window, sum its samples (at most 63) one read at a time through the single
// read port of the 64-entry sample ring, take the last read, load the divider,
// run a restoring divider that resolves one quotient bit a cycle, and load the
// output register. Each sample also has a step of its own to take it and one
// to close it out, so a sample that completes no result ties the block up only
// for those. A stalled output register holds the sequencer until it is free.
// High-pass mode adds no extra state. No clearing pass is needed after reset.

module centered_moving_average_filter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [cmaf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cmaf_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [cmaf_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [cmaf_pkg::VAL_W-1:0]         filtered_value,
    output logic [cmaf_pkg::IDX_W-1:0]                sample_index,
    output logic                                      end_of_record
);

    cmaf_pkg::state_t state_reg, state_next;

    logic [cmaf_pkg::WIN_W-1:0]  window_size_reg;
    logic [cmaf_pkg::IDX_W-1:0]  record_length_reg;
    logic                        high_pass_reg;

    logic [cmaf_pkg::SAMPLE_BITS-1:0] ring [cmaf_pkg::RING_DEPTH];
    logic [cmaf_pkg::SAMPLE_BITS-1:0] rdata_reg;
    logic [cmaf_pkg::RING_AW-1:0]     rd_addr;

    logic [cmaf_pkg::IDX_W-1:0] input_count_reg, input_count_next;
    logic [cmaf_pkg::IDX_W-1:0] e_reg, e_next;
    logic [cmaf_pkg::IDX_W-1:0] last_reg, last_next;
    logic                       any_reg, any_next;
    logic                       final_reg, final_next;
    logic [cmaf_pkg::K_W-1:0]   k_reg, k_next;

    logic [cmaf_pkg::IDX_W-1:0] j_reg, j_next;
    logic [cmaf_pkg::IDX_W-1:0] hi_reg, hi_next;
    logic [cmaf_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic signed [cmaf_pkg::SUM_W-1:0] acc_reg, acc_next;

    logic [cmaf_pkg::SUM_W-1:0]       q_reg, q_next;
    logic [cmaf_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [cmaf_pkg::BIT_W-1:0]       bit_reg, bit_next;
    logic                             neg_reg, neg_next;
    logic [cmaf_pkg::SAMPLE_BITS-1:0] self_reg, self_next;

    logic                             out_valid_reg, out_valid_next;
    logic signed [cmaf_pkg::VAL_W-1:0] out_value_reg, out_value_next;
    logic [cmaf_pkg::IDX_W-1:0]       out_index_reg, out_index_next;
    logic                             out_end_reg, out_end_next;

    logic in_xfer;
    logic out_free;

    // effective record length, window and half window
    logic [cmaf_pkg::IDX_W-1:0] n_eff, n_m1;
    logic [cmaf_pkg::IDX_W-1:0] w_eff;
    logic [cmaf_pkg::IDX_W-1:0] w_half;
    logic [cmaf_pkg::H_W-1:0]   h;

    logic                       final_calc;
    logic [cmaf_pkg::IDX_W:0]   c_plus1;
    logic [cmaf_pkg::IDX_W-1:0] c_plus1_w;

    logic                       go;
    logic [cmaf_pkg::IDX_W:0]   hi_full;
    logic [cmaf_pkg::IDX_W-1:0] hi_calc, lo_calc, lo_clamp, span;

    logic [cmaf_pkg::SUM_W-1:0] rdata_ext;
    logic [cmaf_pkg::SUM_W-1:0] mag;
    logic [cmaf_pkg::CNT_W:0]   rem_sh, rem_diff;
    logic [cmaf_pkg::VAL_W-1:0] q_low, mean, value;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        logic [cmaf_pkg::IDX_W-1:0] w0;
        n_eff = (record_length_reg == '0) ? cmaf_pkg::IDX_W'(1) : record_length_reg;
        n_m1  = n_eff - 1'b1;
        w0    = (window_size_reg == '0) ? cmaf_pkg::IDX_W'(1)
                                        : cmaf_pkg::IDX_W'(window_size_reg);
        if (w0 > cmaf_pkg::IDX_W'(cmaf_pkg::WINDOW_MAX))
            w0 = cmaf_pkg::IDX_W'(cmaf_pkg::WINDOW_MAX);
        w_eff  = (w0 > n_eff) ? n_eff : w0;
        w_half = w_eff >> 1;
        h = (w_half > cmaf_pkg::IDX_W'(cmaf_pkg::H_MAX)) ? cmaf_pkg::H_W'(cmaf_pkg::H_MAX)
                                                          : w_half[cmaf_pkg::H_W-1:0];
    end

    assign c_plus1    = {1'b0, input_count_reg} + 1'b1;
    assign c_plus1_w  = c_plus1[cmaf_pkg::IDX_W-1:0];
    assign final_calc = c_plus1 >= {1'b0, n_eff};

    assign go = any_reg && (e_reg <= last_reg)
             && (k_reg < cmaf_pkg::K_W'(cmaf_pkg::RESULT_CAP));

    always_comb
    begin
        hi_full  = {1'b0, e_reg} + (cmaf_pkg::IDX_W + 1)'(h);
        hi_calc  = (hi_full > {1'b0, n_m1}) ? n_m1 : hi_full[cmaf_pkg::IDX_W-1:0];
        lo_calc  = (e_reg > cmaf_pkg::IDX_W'(h)) ? e_reg - cmaf_pkg::IDX_W'(h) : '0;
        lo_clamp = (lo_calc > hi_calc) ? hi_calc : lo_calc;
        span     = hi_calc - lo_clamp;
    end

    assign rdata_ext = {{(cmaf_pkg::SUM_W - cmaf_pkg::SAMPLE_BITS){rdata_reg[cmaf_pkg::SAMPLE_BITS-1]}},
                        rdata_reg};
    assign mag       = acc_reg[cmaf_pkg::SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign rem_sh    = {rem_reg, q_reg[cmaf_pkg::SUM_W-1]};
    assign rem_diff  = rem_sh - {1'b0, count_reg};
    assign q_low     = q_reg[cmaf_pkg::VAL_W-1:0];
    assign mean      = neg_reg ? (~q_low + 1'b1) : q_low;
    assign value     = high_pass_reg ? ({self_reg[cmaf_pkg::SAMPLE_BITS-1], self_reg} - mean)
                                     : mean;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmaf_pkg::ST_IDLE:    if (in_xfer) state_next = cmaf_pkg::ST_CHECK;
            cmaf_pkg::ST_CHECK:   state_next = go ? cmaf_pkg::ST_SUM : cmaf_pkg::ST_IDLE;
            cmaf_pkg::ST_SUM:     if (j_reg == hi_reg) state_next = cmaf_pkg::ST_TAIL;
            cmaf_pkg::ST_TAIL:    state_next = cmaf_pkg::ST_DIVINIT;
            cmaf_pkg::ST_DIVINIT: state_next = cmaf_pkg::ST_DIV;
            cmaf_pkg::ST_DIV:     if (bit_reg == '0) state_next = cmaf_pkg::ST_RESULT;
            cmaf_pkg::ST_RESULT:  if (out_free) state_next = cmaf_pkg::ST_CHECK;
            default:              state_next = cmaf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall = (state_reg != cmaf_pkg::ST_IDLE);
        rd_addr  = (state_reg == cmaf_pkg::ST_SUM) ? j_reg[cmaf_pkg::RING_AW-1:0]
                                                   : e_reg[cmaf_pkg::RING_AW-1:0];
    end

    // datapath
    always_comb
    begin
        input_count_next = input_count_reg;
        e_next           = e_reg;
        last_next        = last_reg;
        any_next         = any_reg;
        final_next       = final_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        hi_next          = hi_reg;
        count_next       = count_reg;
        rd_pend_next     = 1'b0;
        acc_next         = acc_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        bit_next         = bit_reg;
        neg_next         = neg_reg;
        self_next        = self_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_value_next   = out_value_reg;
        out_index_next   = out_index_reg;
        out_end_next     = out_end_reg;

        unique case (state_reg)
            cmaf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    final_next = final_calc;
                    k_next     = '0;
                    if (final_calc)
                    begin
                        any_next  = 1'b1;
                        last_next = n_m1;
                    end
                    else
                    begin
                        any_next  = input_count_reg >= cmaf_pkg::IDX_W'(h);
                        last_next = (input_count_reg >= cmaf_pkg::IDX_W'(h))
                                  ? input_count_reg - cmaf_pkg::IDX_W'(h) : '0;
                    end
                end
            end
            cmaf_pkg::ST_CHECK:
            begin
                if (go)
                begin
                    j_next     = lo_clamp;
                    hi_next    = hi_calc;
                    count_next = span[cmaf_pkg::CNT_W-1:0] + cmaf_pkg::CNT_W'(1);
                    acc_next   = '0;
                end
                else if (final_reg)
                begin
                    input_count_next = '0;
                    e_next           = '0;
                end
                else
                    input_count_next = c_plus1_w;
            end
            cmaf_pkg::ST_SUM:
            begin
                rd_pend_next = 1'b1;
                j_next       = j_reg + 1'b1;
                if (rd_pend_reg)
                    acc_next = acc_reg + $signed(rdata_ext);
            end
            cmaf_pkg::ST_TAIL:
                acc_next = acc_reg + $signed(rdata_ext);
            cmaf_pkg::ST_DIVINIT:
            begin
                self_next = rdata_reg;
                neg_next  = acc_reg[cmaf_pkg::SUM_W-1];
                q_next    = mag;
                rem_next  = '0;
                bit_next  = cmaf_pkg::BIT_W'(cmaf_pkg::SUM_W - 1);
            end
            cmaf_pkg::ST_DIV:
            begin
                bit_next = bit_reg - 1'b1;
                if (!rem_diff[cmaf_pkg::CNT_W])
                begin
                    rem_next = rem_diff[cmaf_pkg::CNT_W-1:0];
                    q_next   = {q_reg[cmaf_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[cmaf_pkg::CNT_W-1:0];
                    q_next   = {q_reg[cmaf_pkg::SUM_W-2:0], 1'b0};
                end
            end
            cmaf_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = $signed(value);
                    out_index_next = e_reg;
                    out_end_next   = (e_reg == n_m1);
                    e_next         = e_reg + 1'b1;
                    k_next         = k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= cmaf_pkg::WIN_W'(1);
            record_length_reg <= cmaf_pkg::IDX_W'(1);
            high_pass_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cmaf_pkg::REG_WINDOW_SIZE:    window_size_reg   <= cfg_data[cmaf_pkg::WIN_W-1:0];
                cmaf_pkg::REG_RECORD_LENGTH:  record_length_reg <= cfg_data[cmaf_pkg::IDX_W-1:0];
                cmaf_pkg::REG_HIGH_PASS_MODE: high_pass_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            ring[input_count_reg[cmaf_pkg::RING_AW-1:0]] <= sample;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= ring[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cmaf_pkg::ST_IDLE;
            input_count_reg <= '0;
            e_reg           <= '0;
            any_reg         <= 1'b0;
            final_reg       <= 1'b0;
            k_reg           <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            input_count_reg <= input_count_next;
            e_reg           <= e_next;
            any_reg         <= any_next;
            final_reg       <= final_next;
            k_reg           <= k_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        j_reg         <= j_next;
        hi_reg        <= hi_next;
        count_reg     <= count_next;
        acc_reg       <= acc_next;
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        neg_reg       <= neg_next;
        self_reg      <= self_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign sample_index   = out_index_reg;
    assign end_of_record  = out_end_reg;

endmodule

`default_nettype wire
